@@ rtl/core/mbsp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsp_pkg
// types and constants shared by the midi byte stream parser
// ----------------------------------------------------------------------------
package mbsp_pkg;

	typedef enum logic [2:0] {
		EV_NOTE_OFF  = 3'd0,
		EV_NOTE_ON   = 3'd1,
		EV_CTRL      = 3'd2,
		EV_PROGRAM   = 3'd3,
		EV_BEND      = 3'd4,
		EV_SYSEX     = 3'd5
	} event_kind_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SXRD
	} parse_state_t;

	// status bytes
	localparam logic [7:0] ST_SYSEX_START = 8'hF0;
	localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
	localparam logic [7:0] ST_REALTIME    = 8'hF8;
	localparam logic [7:0] ST_TIME_CODE   = 8'hF1;
	localparam logic [7:0] ST_SONG_POS    = 8'hF2;
	localparam logic [7:0] ST_SONG_SEL    = 8'hF3;

	// channel message opcodes (upper nibble of running status)
	localparam logic [3:0] OP_NOTE_OFF = 4'h8;
	localparam logic [3:0] OP_NOTE_ON  = 4'h9;
	localparam logic [3:0] OP_CTRL     = 4'hB;
	localparam logic [3:0] OP_PROGRAM  = 4'hC;
	localparam logic [3:0] OP_BEND     = 4'hE;

	localparam logic [6:0] LEN_MAX = 7'd127;

	typedef struct packed {
		event_kind_t kind;
		logic [3:0]  channel;
		logic [6:0]  first_value;
		logic [6:0]  second_value;
		logic [13:0] bend_value;
		logic [7:0]  sysex_byte;
		logic        sysex_byte_valid;
		logic [6:0]  sysex_length;
		logic        sysex_overflow;
		logic        last;
	} result_t;

endpackage

@@ rtl/core/mbsp_sysex_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsp_sysex_mem
// system exclusive byte store, one write port and one registered read port
// ----------------------------------------------------------------------------
module mbsp_sysex_mem #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/core/midi_byte_stream_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_byte_stream_parser
// running status midi parser with a system exclusive store and readout
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_stall | data_byte
//  out     | out_valid/out_stall | event_kind, channel, first_value,
//          |                     | second_value, bend_value, sysex_byte,
//          |                     | sysex_byte_valid, sysex_length,
//          |                     | sysex_overflow, last
//
//  a byte is taken in S_IDLE and decoded in S_EXEC
//  an end of sysex then reads the store at one byte a cycle through the
//  single read port, as long as the output is not stalled
//  arst_n clears the parser state; the store needs no clearing, as only
//  entries written since the last sysex start are ever read
//  a stalled output holds the result and the decode or readout waits on it;
//  a new input transaction is still taken while a result waits
// ----------------------------------------------------------------------------
module midi_byte_stream_parser
	import mbsp_pkg::*;
#(
	parameter int SYSEX_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_kind,
	output logic [3:0]  channel,
	output logic [6:0]  first_value,
	output logic [6:0]  second_value,
	output logic [13:0] bend_value,
	output logic [7:0]  sysex_byte,
	output logic        sysex_byte_valid,
	output logic [6:0]  sysex_length,
	output logic        sysex_overflow,
	output logic        last
);

	localparam int CNT_W  = $clog2(SYSEX_DEPTH + 1);
	localparam int ADDR_W = (SYSEX_DEPTH > 1) ? $clog2(SYSEX_DEPTH) : 1;
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SYSEX_DEPTH);

	// control state
	parse_state_t     state_q, state_d;
	logic [7:0]       byte_q;
	logic [7:0]       rs_q, rs_d;
	logic             await_q, await_d;
	logic [6:0]       first_q, first_d;
	logic             in_sysex_q, in_sysex_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             dropped_q, dropped_d;
	logic [ADDR_W-1:0] rd_idx_q, rd_idx_d;

	// output register
	logic    out_valid_q;
	result_t out_q;
	result_t res;
	logic    load;
	logic    out_free;

	// store access
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_data;

	// decode helpers
	logic       fin_take;
	logic [6:0] fin_first;
	logic [6:0] fin_second;
	logic [3:0] op;
	logic [6:0] sx_len;
	logic       rd_last;
	logic       need_out;
	logic       commit;

	mbsp_sysex_mem #(
		.DEPTH  (SYSEX_DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (byte_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign op       = rs_q[7:4];

	// length saturates at the field's top value
	assign sx_len  = (32'(count_q) > 32'(LEN_MAX)) ? LEN_MAX : 7'(count_q);
	assign rd_last = ((CNT_W'(rd_idx_q) + CNT_W'(1)) == count_q);

	// a data byte completes a message when the second byte was pending, or
	// straight away for program change and channel pressure
	assign fin_take   = !in_sysex_q && !byte_q[7] &&
		(await_q || (rs_q[7:5] == 3'b110));
	assign fin_first  = await_q ? first_q : byte_q[6:0];
	assign fin_second = await_q ? byte_q[6:0] : 7'd0;

	always_comb begin
		state_d    = state_q;
		rs_d       = rs_q;
		await_d    = await_q;
		first_d    = first_q;
		in_sysex_d = in_sysex_q;
		count_d    = count_q;
		dropped_d  = dropped_q;
		rd_idx_d   = rd_idx_q;
		wr_en      = 1'b0;
		wr_addr    = count_q[ADDR_W-1:0];
		rd_en      = 1'b0;
		rd_addr    = rd_idx_q;
		need_out   = 1'b0;
		commit     = 1'b0;
		load       = 1'b0;

		res                  = '0;
		res.kind             = EV_SYSEX;
		res.channel          = rs_q[3:0];
		res.first_value      = fin_first;
		res.sysex_overflow   = dropped_q;
		res.last             = 1'b1;

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end

			S_EXEC: begin
				if (in_sysex_q) begin
					if (byte_q == ST_SYSEX_END) begin
						// empty message gives one result, otherwise start readout
						need_out = (count_q == '0);
						res.channel     = 4'd0;
						res.first_value = 7'd0;
					end
				end else if (fin_take) begin
					need_out = 1'b1;
					case (op)
						OP_NOTE_OFF: begin
							res.kind = EV_NOTE_OFF;
						end
						OP_NOTE_ON: begin
							// velocity zero is a note off
							if (fin_second == 7'd0) begin
								res.kind = EV_NOTE_OFF;
							end else begin
								res.kind         = EV_NOTE_ON;
								res.second_value = fin_second;
							end
						end
						OP_CTRL: begin
							res.kind         = EV_CTRL;
							res.second_value = fin_second;
						end
						OP_PROGRAM: begin
							res.kind = EV_PROGRAM;
						end
						OP_BEND: begin
							res.kind        = EV_BEND;
							res.first_value = 7'd0;
							res.bend_value  = {fin_second, fin_first};
						end
						default: begin
							// pressure and song position data: no result
							need_out = 1'b0;
						end
					endcase
					res.sysex_overflow = 1'b0;
				end

				commit = !need_out || out_free;
				load   = need_out && out_free;

				if (commit) begin
					state_d = S_IDLE;
					if (in_sysex_q) begin
						if (byte_q == ST_SYSEX_END) begin
							in_sysex_d = 1'b0;
							if (count_q != '0) begin
								rd_en    = 1'b1;
								rd_addr  = '0;
								rd_idx_d = '0;
								state_d  = S_SXRD;
							end
						end else if (count_q < CNT_FULL) begin
							wr_en   = 1'b1;
							count_d = count_q + CNT_W'(1);
						end else begin
							dropped_d = 1'b1;
						end
					end else if (byte_q[7]) begin
						if (byte_q < ST_REALTIME) begin
							rs_d    = byte_q;
							await_d = 1'b0;
							if (byte_q == ST_SYSEX_START) begin
								in_sysex_d = 1'b1;
								count_d    = '0;
								dropped_d  = 1'b0;
							end
						end
					end else if (await_q) begin
						await_d = 1'b0;
					end else if (rs_q != 8'd0) begin
						if ((rs_q[7:6] == 2'b10) || (op == OP_BEND)) begin
							await_d = 1'b1;
							first_d = byte_q[6:0];
						end else if (rs_q[7:5] == 3'b110) begin
							first_d = byte_q[6:0];
						end else if (rs_q == ST_SONG_POS) begin
							rs_d    = 8'd0;
							await_d = 1'b1;
							first_d = byte_q[6:0];
						end else begin
							if ((rs_q == ST_TIME_CODE) || (rs_q == ST_SONG_SEL)) begin
								first_d = byte_q[6:0];
							end
							rs_d = 8'd0;
						end
					end
				end
			end

			S_SXRD: begin
				// read data for rd_idx_q is ready; issue the next read on load
				res.channel          = 4'd0;
				res.first_value      = 7'd0;
				res.sysex_byte       = rd_data;
				res.sysex_byte_valid = 1'b1;
				res.sysex_length     = sx_len;
				res.last             = rd_last;
				need_out             = 1'b1;
				load                 = out_free;
				if (out_free) begin
					if (rd_last) begin
						state_d = S_IDLE;
					end else begin
						rd_idx_d = rd_idx_q + ADDR_W'(1);
						rd_en    = 1'b1;
						rd_addr  = rd_idx_q + ADDR_W'(1);
					end
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			rs_q       <= 8'd0;
			await_q    <= 1'b0;
			first_q    <= 7'd0;
			in_sysex_q <= 1'b0;
			count_q    <= '0;
			dropped_q  <= 1'b0;
			rd_idx_q   <= '0;
		end else begin
			state_q    <= state_d;
			rs_q       <= rs_d;
			await_q    <= await_d;
			first_q    <= first_d;
			in_sysex_q <= in_sysex_d;
			count_q    <= count_d;
			dropped_q  <= dropped_d;
			rd_idx_q   <= rd_idx_d;
		end
	end

	// input byte capture on an accepted transaction
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_q <= data_byte;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign event_kind       = out_q.kind;
	assign channel          = out_q.channel;
	assign first_value      = out_q.first_value;
	assign second_value     = out_q.second_value;
	assign bend_value       = out_q.bend_value;
	assign sysex_byte       = out_q.sysex_byte;
	assign sysex_byte_valid = out_q.sysex_byte_valid;
	assign sysex_length     = out_q.sysex_length;
	assign sysex_overflow   = out_q.sysex_overflow;
	assign last             = out_q.last;

	// readout only runs over a non-empty store, outside sysex
	a_sxrd_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SXRD) |-> ((count_q != '0) && !in_sysex_q))
		else $error("readout with empty store or open sysex");

	a_sxrd_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SXRD) |-> (CNT_W'(rd_idx_q) < count_q))
		else $error("readout index past stored length");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("sysex count beyond store depth");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		dropped_q |-> (count_q == CNT_FULL))
		else $error("overflow flagged with room left in store");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SXRD && load && rd_last) |=> (state_q == S_IDLE))
		else $error("readout continued after final byte");

endmodule

@@ dv/mbsp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsp_checker
// watches both channels of the midi byte stream parser, predicts the events
// each accepted byte causes and compares every output transaction in order
// ----------------------------------------------------------------------------
module mbsp_checker
	import mbsp_pkg::*;
#(
	parameter int SYSEX_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  event_kind,
	input  logic [3:0]  channel,
	input  logic [6:0]  first_value,
	input  logic [6:0]  second_value,
	input  logic [13:0] bend_value,
	input  logic [7:0]  sysex_byte,
	input  logic        sysex_byte_valid,
	input  logic [6:0]  sysex_length,
	input  logic        sysex_overflow,
	input  logic        last,
	output int          fail_count,
	output int          outstanding,
	output int          checked_count
);

	// parser state as the block should hold it
	logic [7:0] run_status;
	logic       await_second;
	logic [7:0] first_data_q;
	logic       in_sysex_q;
	int         sx_count;
	logic       sx_dropped;
	logic [7:0] sx_store [SYSEX_DEPTH];

	result_t pending_events [$];
	int      errors_seen;
	int      results_seen;

	task automatic push_channel_event(input event_kind_t k, input logic [3:0] ch,
			input logic [6:0] v1, input logic [6:0] v2, input logic [13:0] bend);
		result_t r;
		r = '0;
		r.kind         = k;
		r.channel      = ch;
		r.first_value  = v1;
		r.second_value = v2;
		r.bend_value   = bend;
		r.last         = 1'b1;
		pending_events.push_back(r);
	endtask

	task automatic push_sysex_item(input logic [7:0] b, input logic b_valid,
			input logic [6:0] len, input logic ovf, input logic is_last);
		result_t r;
		r = '0;
		r.kind             = EV_SYSEX;
		r.sysex_byte       = b;
		r.sysex_byte_valid = b_valid;
		r.sysex_length     = len;
		r.sysex_overflow   = ovf;
		r.last             = is_last;
		pending_events.push_back(r);
	endtask

	task automatic close_channel_message(input logic [6:0] second);
		logic [3:0] op;
		logic [3:0] ch;
		op = run_status[7:4];
		ch = run_status[3:0];
		// note on with zero velocity counts as note off
		if (op == OP_NOTE_ON && second == 7'd0)
			op = OP_NOTE_OFF;
		case (op)
			OP_NOTE_OFF: push_channel_event(EV_NOTE_OFF, ch, first_data_q[6:0], 7'd0, 14'd0);
			OP_NOTE_ON:  push_channel_event(EV_NOTE_ON, ch, first_data_q[6:0], second, 14'd0);
			OP_CTRL:     push_channel_event(EV_CTRL, ch, first_data_q[6:0], second, 14'd0);
			OP_PROGRAM:  push_channel_event(EV_PROGRAM, ch, first_data_q[6:0], 7'd0, 14'd0);
			OP_BEND:     push_channel_event(EV_BEND, ch, 7'd0, 7'd0, {second, first_data_q[6:0]});
			default: ;
		endcase
	endtask

	task automatic release_sysex;
		logic [6:0] len;
		len = (sx_count > LEN_MAX) ? LEN_MAX : 7'(sx_count);
		if (sx_count == 0)
			push_sysex_item(8'd0, 1'b0, 7'd0, sx_dropped, 1'b1);
		else
			for (int k = 0; k < sx_count && k < SYSEX_DEPTH; k++)
				push_sysex_item(sx_store[k], 1'b1, len, sx_dropped, k + 1 == sx_count);
	endtask

	task automatic absorb_byte(input logic [7:0] d);
		logic [3:0] op;
		op = run_status[7:4];
		if (in_sysex_q) begin
			if (d == ST_SYSEX_END) begin
				in_sysex_q = 1'b0;
				release_sysex();
			end else if (sx_count < SYSEX_DEPTH) begin
				sx_store[sx_count] = d;
				sx_count++;
			end else
				sx_dropped = 1'b1;
		end else if (d[7]) begin
			if (d < ST_REALTIME) begin
				run_status   = d;
				await_second = 1'b0;
				if (d == ST_SYSEX_START) begin
					in_sysex_q = 1'b1;
					sx_count   = 0;
					sx_dropped = 1'b0;
				end
			end
		end else if (await_second) begin
			await_second = 1'b0;
			close_channel_message(d[6:0]);
		end else if (run_status != 8'd0) begin
			if (op < OP_PROGRAM || op == OP_BEND) begin
				await_second = 1'b1;
				first_data_q = d;
			end else if (op < OP_BEND) begin
				first_data_q = d;
				close_channel_message(7'd0);
			end else if (run_status == ST_SONG_POS) begin
				// two data bytes swallowed, the second via the pending flag
				run_status   = 8'd0;
				await_second = 1'b1;
				first_data_q = d;
			end else begin
				if (run_status == ST_TIME_CODE || run_status == ST_SONG_SEL)
					first_data_q = d;
				run_status = 8'd0;
			end
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors_seen++;
		end
	endtask

	task automatic check_result;
		result_t want;
		if (pending_events.size() == 0) begin
			$display("%0t: unexpected result, expected none, got kind %0d channel %0d",
				$time, event_kind, channel);
			$display("%0t: unexpected result has byte %0d last %0d",
				$time, sysex_byte, last);
			errors_seen++;
		end else begin
			want = pending_events.pop_front();
			results_seen++;
			check_field("event_kind", 16'(want.kind), 16'(event_kind));
			check_field("channel", 16'(want.channel), 16'(channel));
			check_field("first_value", 16'(want.first_value), 16'(first_value));
			check_field("second_value", 16'(want.second_value), 16'(second_value));
			check_field("bend_value", 16'(want.bend_value), 16'(bend_value));
			check_field("sysex_byte", 16'(want.sysex_byte), 16'(sysex_byte));
			check_field("sysex_byte_valid", 16'(want.sysex_byte_valid),
				16'(sysex_byte_valid));
			check_field("sysex_length", 16'(want.sysex_length), 16'(sysex_length));
			check_field("sysex_overflow", 16'(want.sysex_overflow), 16'(sysex_overflow));
			check_field("last", 16'(want.last), 16'(last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_status   = 8'd0;
			await_second = 1'b0;
			first_data_q = 8'd0;
			in_sysex_q   = 1'b0;
			sx_count     = 0;
			sx_dropped   = 1'b0;
			pending_events.delete();
			errors_seen  = 0;
			results_seen = 0;
			fail_count    <= 0;
			outstanding   <= 0;
			checked_count <= 0;
		end else begin
			// output first: a result never comes from a byte taken at the same edge
			if (out_valid && !out_stall)
				check_result();
			if (in_valid && !in_stall)
				absorb_byte(data_byte);
			fail_count    <= errors_seen;
			outstanding   <= pending_events.size();
			checked_count <= results_seen;
		end
	end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives midi byte streams into the parser under varying idle and stall
// patterns and reports the verdict from the checker alongside the block
// ----------------------------------------------------------------------------
module tb_top
	import mbsp_pkg::*;
();

	localparam int CLK_PERIOD     = 8;
	localparam int SYSEX_DEPTH    = 64;
	localparam int TOTAL_BYTES    = 470;
	localparam int LONG_HOLD      = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 100;
	localparam int N_DIRECTED     = 33;

	// opcodes and status bytes the package has no name for
	localparam logic [3:0] OP_CHAN_PRESS  = 4'hD;
	localparam logic [7:0] ST_RT_RESET    = 8'hFF;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  event_kind;
	logic [3:0]  channel;
	logic [6:0]  first_value;
	logic [6:0]  second_value;
	logic [13:0] bend_value;
	logic [7:0]  sysex_byte;
	logic        sysex_byte_valid;
	logic [6:0]  sysex_length;
	logic        sysex_overflow;
	logic        last;

	int fail_count;
	int outstanding;
	int checked_count;

	// knobs shared between the stimulus, the output stall process and the summary
	int send_idle_pct;
	int stall_pct;
	bit hold_requested;
	int bytes_sent;
	int sysex_sent;
	int quiet_cycles;

	midi_byte_stream_parser #(
		.SYSEX_DEPTH(SYSEX_DEPTH)
	) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.data_byte        (data_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.event_kind       (event_kind),
		.channel          (channel),
		.first_value      (first_value),
		.second_value     (second_value),
		.bend_value       (bend_value),
		.sysex_byte       (sysex_byte),
		.sysex_byte_valid (sysex_byte_valid),
		.sysex_length     (sysex_length),
		.sysex_overflow   (sysex_overflow),
		.last             (last)
	);

	mbsp_checker #(
		.SYSEX_DEPTH(SYSEX_DEPTH)
	) u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.data_byte        (data_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.event_kind       (event_kind),
		.channel          (channel),
		.first_value      (first_value),
		.second_value     (second_value),
		.bend_value       (bend_value),
		.sysex_byte       (sysex_byte),
		.sysex_byte_valid (sysex_byte_valid),
		.sysex_length     (sysex_length),
		.sysex_overflow   (sysex_overflow),
		.last             (last),
		.fail_count       (fail_count),
		.outstanding      (outstanding),
		.checked_count    (checked_count)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// output side: random stall each cycle, or one long hold when asked for
	// the hold is counted here so the sender keeps offering bytes meanwhile
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requested) begin
				hold_requested = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d results still due",
					$time, WATCHDOG_LIMIT, outstanding);
				$display("TB_ERROR");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one input transaction, preceded by a random idle gap
	// valid is lowered only during a gap, so back-to-back bytes keep it high
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	// data bytes lean towards the extremes now and then
	function automatic logic [7:0] random_data();
		int r;
		r = $urandom_range(99);
		if (r < 12)
			return 8'h00;
		else if (r < 22)
			return 8'h7F;
		return 8'($urandom_range(127));
	endfunction

	// a real-time byte may fall between any two bytes of a channel message
	task automatic maybe_realtime;
		if ($urandom_range(99) < 5)
			send_byte(8'($urandom_range(ST_RT_RESET, ST_REALTIME)));
	endtask

	task automatic send_channel_message;
		logic [3:0] op;
		int n_data;
		op = 4'($urandom_range(OP_BEND, OP_NOTE_OFF));
		// a quarter of the messages lean on running status
		if ($urandom_range(99) < 75)
			send_byte({op, 4'($urandom_range(15))});
		n_data = (op == OP_PROGRAM || op == OP_CHAN_PRESS) ? 1 : 2;
		for (int i = 0; i < n_data; i++) begin
			maybe_realtime();
			send_byte(random_data());
		end
	endtask

	task automatic send_sysex;
		int r;
		int len;
		logic [7:0] b;
		r = $urandom_range(99);
		if (r < 65)
			len = $urandom_range(6);
		else if (r < 90)
			len = $urandom_range(30, 7);
		else
			len = $urandom_range(SYSEX_DEPTH + 6, SYSEX_DEPTH - 4);
		send_byte(ST_SYSEX_START);
		repeat (len) begin
			// any byte but the terminator is stored, status and real-time included
			b = 8'($urandom_range(255));
			if (b == ST_SYSEX_END)
				b = 8'($urandom_range(127));
			send_byte(b);
		end
		send_byte(ST_SYSEX_END);
		sysex_sent++;
	endtask

	task automatic send_system_common;
		logic [7:0] st;
		int n_data;
		st = 8'($urandom_range(ST_SYSEX_END, ST_TIME_CODE));
		if (st == ST_SONG_POS)
			n_data = 2;
		else if (st == ST_TIME_CODE || st == ST_SONG_SEL)
			n_data = 1;
		else
			n_data = $urandom_range(1);
		send_byte(st);
		repeat (n_data) send_byte(random_data());
	endtask

	task automatic send_message;
		int r;
		r = $urandom_range(99);
		if (r < 60)
			send_channel_message();
		else if (r < 75)
			send_sysex();
		else if (r < 85)
			send_system_common();
		else if (r < 92)
			send_byte(8'($urandom_range(ST_RT_RESET, ST_REALTIME)));
		else
			send_byte(8'($urandom_range(255)));
	endtask

	initial begin
		logic [7:0] directed [N_DIRECTED];
		int idle_by_phase [4];
		int stall_by_phase [4];
		int target;

		// every input at a known level from time zero
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		data_byte      = 8'd0;
		send_idle_pct  = 0;
		stall_pct      = 0;
		hold_requested = 1'b0;
		bytes_sent     = 0;
		sysex_sent     = 0;
		quiet_cycles   = 0;
		idle_by_phase  = '{0, 53, 0, 13};
		stall_by_phase = '{0, 0, 53, 13};

		directed = '{
			8'h00,                                  // data with no running status
			{OP_NOTE_ON, 4'h0}, 8'h3C, 8'h7F,       // note on
			8'h3C, 8'h00,                           // running status, zero velocity
			{OP_NOTE_OFF, 4'hF}, 8'h7F, 8'h7F,      // note off, top channel and values
			{OP_CTRL, 4'hA}, 8'h00, 8'h40,          // control change
			{OP_PROGRAM, 4'h3}, 8'h7F,              // program change
			{OP_BEND, 4'h7}, 8'h7F, ST_REALTIME, 8'h7F, // full bend, clock byte inside
			{OP_CHAN_PRESS, 4'h2}, 8'h10,           // channel pressure, no event
			ST_SONG_POS, 8'h01, 8'h02,              // song position swallows two
			ST_SONG_SEL, 8'h05,                     // song select swallows one
			ST_SYSEX_START, ST_SYSEX_END,           // empty sysex
			8'h55,                                  // data after the stale sysex start
			ST_SYSEX_START, {OP_NOTE_ON, 4'h1}, ST_RT_RESET, 8'h00, ST_SYSEX_END
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_byte(directed[i]);

		// four idling phases share what is left of the byte budget
		// the first one also holds the output off for a long stretch
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_by_phase[p];
			stall_pct     = stall_by_phase[p];
			if (p == 0)
				hold_requested = 1'b1;
			target = bytes_sent + (TOTAL_BYTES - bytes_sent) / (4 - p);
			while (bytes_sent < target)
				send_message();
		end

		in_valid  <= 1'b0;
		stall_pct = 0;
		// the checker count is registered, so it lags the checker's queue
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d bytes incl. %0d sysex messages", bytes_sent, sysex_sent);
		$display("four idle/stall phases and a long hold, compared %0d events, %0d mismatches",
			checked_count, fail_count);
		if (fail_count == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/mbsp_pkg.sv
rtl/core/mbsp_sysex_mem.sv
rtl/core/midi_byte_stream_parser.sv
dv/mbsp_checker.sv
dv/tb_top.sv
